[rtl/cplm_pkg.sv]
// ----------------------------------------------------------------------------
// CPU load monitor package
// Shared types, action codes and state encoding of the CPU load monitor.
// ----------------------------------------------------------------------------
package cplm_pkg;

  // Default width of the idle count that takes part in the arithmetic
  localparam int unsigned CPLM_COUNT_WIDTH = 32;

  // Percentage scale and the quotient width it implies (quotients stay at or below 100)
  localparam int unsigned PCT_SCALE = 100;
  localparam int unsigned QUO_W     = 7;
  localparam int unsigned DIV_STEPS = QUO_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);
  localparam int unsigned TTH_W     = 14;

  typedef enum logic [1:0] {
    ACT_SAMPLE    = 2'd0,
    ACT_READ_CUR  = 2'd1,
    ACT_READ_PEAK = 2'd2,
    ACT_SET_EN    = 2'd3
  } cplm_action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_DIV1,
    ST_MUL2,
    ST_DIV2,
    ST_PEAK
  } cplm_state_t;

  typedef struct packed {
    cplm_action_t action;
    logic [31:0]  idle_count;
    logic         enable_value;
  } cplm_in_t;

  typedef struct packed {
    logic [QUO_W-1:0] usage_whole;
    logic [QUO_W-1:0] usage_hundredths;
    logic [TTH_W-1:0] usage_ten_thousandths;
  } cplm_out_t;

  // Combine whole and hundredths into ten-thousandths
  function automatic logic [TTH_W-1:0] ten_thousandths(input logic [QUO_W-1:0] whole,
                                                        input logic [QUO_W-1:0] hund);
    return TTH_W'(whole) * TTH_W'(PCT_SCALE) + TTH_W'(hund);
  endfunction

endpackage

[rtl/cpu_load_percent_monitor.sv]
// ----------------------------------------------------------------------------
// CPU load percent monitor
// Turns per-window idle counts into a load percentage with peak hold.
// ----------------------------------------------------------------------------
// Each input transaction carries an action: a window sample with its idle
// count, a read of the current load, a read of the peak (which rearms the
// peak hold) or an enable change. The first sample seen while the reference is
// zero becomes the full-idle reference. With statistics enabled, a sample
// below the reference gives load = (ref - count) * 100 / ref as whole percent
// plus two decimals, worked out by one shared 7-step restoring divider that
// is used twice; a sample at or above the reference replaces it and reads as
// 100.00. A sample that needs division passes a multiply-by-100 state and a
// divide pass twice, then a peak-update state; one without division goes
// straight to peak update; reads and enable changes are handled on acceptance
// without leaving idle. The divider gives one quotient bit per cycle.
// The input is not ready while a sample is in work, and no transaction is
// taken while a previous result sits unaccepted on the output register. Writing
// the config register loads the enable state directly; write it only while idle.
// ----------------------------------------------------------------------------
module cpu_load_percent_monitor #(
  parameter int unsigned COUNT_WIDTH = cplm_pkg::CPLM_COUNT_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cplm_pkg::cplm_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cplm_pkg::cplm_out_t out_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);
  import cplm_pkg::*;

  localparam int unsigned PROD_W = COUNT_WIDTH + QUO_W;

  cplm_state_t             state_r, state_nxt;

  // Calibration reference and statistics state
  logic [COUNT_WIDTH-1:0]  ref_r;
  logic [QUO_W-1:0]        cur_whole_r, cur_hund_r;
  logic [QUO_W-1:0]        peak_whole_r, peak_hund_r;
  logic                    armed_r;
  logic                    en_r;
  logic                    out_valid_r;

  // Shared divider datapath
  logic [COUNT_WIDTH-1:0]  rem_r;
  logic [QUO_W-1:0]        lo_r;
  logic [QUO_W-1:0]        quo_r;
  logic [STEP_W-1:0]       step_r;
  cplm_out_t               out_data_r;

  logic                    in_fire;
  logic [COUNT_WIDTH-1:0]  count;
  logic [COUNT_WIDTH-1:0]  ref_eff;
  logic                    need_div;
  logic [PROD_W-1:0]       prod;
  logic [COUNT_WIDTH:0]    trial;
  logic [COUNT_WIDTH:0]    diff;
  logic                    fits;
  logic [COUNT_WIDTH-1:0]  rem_step;
  logic [QUO_W-1:0]        q_next;
  logic                    last_step;
  logic                    new_peak;

  // Take a new transaction only when idle and the output register can hold a result
  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Only the low COUNT_WIDTH bits of the count matter
  assign count    = in_data.idle_count[COUNT_WIDTH-1:0];
  // An uncalibrated monitor adopts this count as reference first
  assign ref_eff  = (ref_r == '0) ? count : ref_r;
  assign need_div = count < ref_eff;

  // Scale by 100; the quotient is below 128, so the top part starts below ref
  assign prod = PROD_W'(rem_r) * PROD_W'(PCT_SCALE);

  // One restoring-divide step: bring in the next dividend bit, subtract if it fits
  assign trial     = {rem_r, lo_r[QUO_W-1]};
  assign fits      = trial >= {1'b0, ref_r};
  assign diff      = trial - {1'b0, ref_r};
  assign rem_step  = fits ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
  assign q_next    = {quo_r[QUO_W-2:0], fits};
  assign last_step = step_r == STEP_W'(DIV_STEPS - 1);

  // Hundredths stay below 100, so the concatenation orders like the value
  assign new_peak = !armed_r || ({cur_whole_r, cur_hund_r} > {peak_whole_r, peak_hund_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_data.action == ACT_SAMPLE && en_r) begin
          state_nxt = need_div ? ST_MUL1 : ST_PEAK;
        end
      end
      ST_MUL1: state_nxt = ST_DIV1;
      ST_DIV1: begin
        if (last_step) begin
          state_nxt = ST_MUL2;
        end
      end
      ST_MUL2: state_nxt = ST_DIV2;
      ST_DIV2: begin
        if (last_step) begin
          state_nxt = ST_PEAK;
        end
      end
      ST_PEAK: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and statistics state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r        <= '0;
      cur_whole_r  <= '0;
      cur_hund_r   <= '0;
      peak_whole_r <= '0;
      peak_hund_r  <= '0;
      armed_r      <= 1'b0;
      en_r         <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      // Raise valid for an accepted read, drop it once the result is taken
      if (in_fire && (in_data.action inside {ACT_READ_CUR, ACT_READ_PEAK})) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        en_r <= cfg_wr_data;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_data.action) inside
              ACT_SAMPLE: begin
                // Calibrate on an empty reference; when enabled, a count at or
                // above the reference becomes the new reference and saturates
                if (ref_r == '0 || (en_r && !need_div)) begin
                  ref_r <= count;
                end
                if (en_r && !need_div) begin
                  cur_whole_r <= QUO_W'(PCT_SCALE);
                  cur_hund_r  <= '0;
                end
              end
              ACT_READ_CUR, ACT_READ_PEAK: begin
                if (in_data.action == ACT_READ_PEAK) begin
                  armed_r <= 1'b0;
                end
              end
              ACT_SET_EN: begin
                en_r <= in_data.enable_value;
                if (!in_data.enable_value) begin
                  cur_whole_r  <= '0;
                  cur_hund_r   <= '0;
                  peak_whole_r <= '0;
                  peak_hund_r  <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_DIV1: begin
          if (last_step) begin
            cur_whole_r <= q_next;
          end
        end
        ST_DIV2: begin
          if (last_step) begin
            cur_hund_r <= q_next;
          end
        end
        ST_PEAK: begin
          if (new_peak) begin
            armed_r      <= 1'b1;
            peak_whole_r <= cur_whole_r;
            peak_hund_r  <= cur_hund_r;
          end
        end
        default: ;
      endcase
    end
  end

  // Divider datapath and output payload
  always_ff @(posedge clk) begin
    case (state_r) inside
      ST_IDLE: begin
        if (in_fire) begin
          // Busy share feeds the first scale-and-divide pass
          rem_r <= ref_eff - count;
          if (in_data.action == ACT_READ_CUR) begin
            out_data_r.usage_whole           <= cur_whole_r;
            out_data_r.usage_hundredths      <= cur_hund_r;
            out_data_r.usage_ten_thousandths <= ten_thousandths(cur_whole_r, cur_hund_r);
          end else if (in_data.action == ACT_READ_PEAK) begin
            out_data_r.usage_whole           <= peak_whole_r;
            out_data_r.usage_hundredths      <= peak_hund_r;
            out_data_r.usage_ten_thousandths <= ten_thousandths(peak_whole_r, peak_hund_r);
          end
        end
      end
      ST_MUL1, ST_MUL2: begin
        rem_r  <= prod[PROD_W-1:QUO_W];
        lo_r   <= prod[QUO_W-1:0];
        step_r <= '0;
      end
      ST_DIV1, ST_DIV2: begin
        rem_r  <= rem_step;
        lo_r   <= {lo_r[QUO_W-2:0], 1'b0};
        quo_r  <= q_next;
        step_r <= step_r + STEP_W'(1);
      end
      default: ;
    endcase
  end

endmodule

[rtl/cplm_checker.sv]
// ----------------------------------------------------------------------------
// CPU load monitor checker
// Port-level checks of result encoding and read latency, bound to the top.
// ----------------------------------------------------------------------------
module cplm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input cplm_pkg::cplm_in_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input cplm_pkg::cplm_out_t out_data
);
  import cplm_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A read transaction shows its result on the next cycle
  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready &&
    (in_data.action == ACT_READ_CUR || in_data.action == ACT_READ_PEAK) |=> out_valid)
    else $error("read gave no result");

  // Load never exceeds 100.00
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.usage_hundredths < QUO_W'(PCT_SCALE) &&
    (out_data.usage_whole < QUO_W'(PCT_SCALE) ||
     (out_data.usage_whole == QUO_W'(PCT_SCALE) && out_data.usage_hundredths == '0)))
    else $error("load out of range");

  // The combined field agrees with whole and hundredths
  a_combined: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.usage_ten_thousandths ==
      ten_thousandths(out_data.usage_whole, out_data.usage_hundredths))
    else $error("ten-thousandths mismatch");

endmodule

bind cpu_load_percent_monitor cplm_checker u_cplm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
